@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/cste_pkg.sv @@
// ----------------------------------------------------------------------------
// cste_pkg
// Types, constants and the arithmetic program of the spline evaluator.
// ----------------------------------------------------------------------------
package cste_pkg;

   localparam int MAX_POINTS = 256;
   localparam int FRAC_BITS  = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int KNOT_W     = 32;
   localparam int WIDE_W     = 64;
   localparam int PC_W       = 6;

   localparam logic [WIDE_W-1:0] SAT_LIM = 64'h4000_0000_0000_0000;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV16, OP_DIV0, OP_CHK, OP_END
   } op_type;

   typedef enum logic [3:0] {
      SRC_XQ, SRC_XLO, SRC_XHI, SRC_YLO, SRC_YHI, SRC_CLO, SRC_CHI, SRC_DX,
      SRC_NA, SRC_NB, SRC_SIX, SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_Y
   } src_type;

   typedef struct packed {
      op_type  op;
      src_type a;
      src_type b;
      src_type dst;
   } instr_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_req_type;

   localparam logic [PC_W-1:0] PC_ABOVE  = 6'd0;
   localparam logic [PC_W-1:0] PC_BELOW  = 6'd11;
   localparam logic [PC_W-1:0] PC_INSIDE = 6'd22;

   function automatic instr_type prog_rom(input logic [PC_W-1:0] pc);
      instr_type r;
      case (pc)
         // tangent beyond the upper knot
         6'd0:  r = '{OP_SUB,   SRC_YHI, SRC_YLO, SRC_T0};
         6'd1:  r = '{OP_DIV16, SRC_T0,  SRC_DX,  SRC_T0};
         6'd2:  r = '{OP_ADD,   SRC_CHI, SRC_CHI, SRC_T1};
         6'd3:  r = '{OP_ADD,   SRC_T1,  SRC_CLO, SRC_T1};
         6'd4:  r = '{OP_MUL,   SRC_DX,  SRC_T1,  SRC_T1};
         6'd5:  r = '{OP_DIV0,  SRC_T1,  SRC_SIX, SRC_T1};
         6'd6:  r = '{OP_ADD,   SRC_T0,  SRC_T1,  SRC_T0};
         6'd7:  r = '{OP_SUB,   SRC_XQ,  SRC_XHI, SRC_T2};
         6'd8:  r = '{OP_MUL,   SRC_T0,  SRC_T2,  SRC_T2};
         6'd9:  r = '{OP_ADD,   SRC_YHI, SRC_T2,  SRC_Y};
         // tangent below the lower knot
         6'd11: r = '{OP_SUB,   SRC_YHI, SRC_YLO, SRC_T0};
         6'd12: r = '{OP_DIV16, SRC_T0,  SRC_DX,  SRC_T0};
         6'd13: r = '{OP_ADD,   SRC_CLO, SRC_CLO, SRC_T1};
         6'd14: r = '{OP_ADD,   SRC_T1,  SRC_CHI, SRC_T1};
         6'd15: r = '{OP_MUL,   SRC_DX,  SRC_T1,  SRC_T1};
         6'd16: r = '{OP_DIV0,  SRC_T1,  SRC_SIX, SRC_T1};
         6'd17: r = '{OP_SUB,   SRC_T0,  SRC_T1,  SRC_T0};
         6'd18: r = '{OP_SUB,   SRC_XQ,  SRC_XLO, SRC_T2};
         6'd19: r = '{OP_MUL,   SRC_T0,  SRC_T2,  SRC_T2};
         6'd20: r = '{OP_ADD,   SRC_YLO, SRC_T2,  SRC_Y};
         // inside the segment
         6'd22: r = '{OP_DIV16, SRC_NA,  SRC_DX,  SRC_T0};
         6'd23: r = '{OP_DIV16, SRC_NB,  SRC_DX,  SRC_T1};
         6'd24: r = '{OP_MUL,   SRC_T0,  SRC_YLO, SRC_T2};
         6'd25: r = '{OP_MUL,   SRC_T1,  SRC_YHI, SRC_T3};
         6'd26: r = '{OP_ADD,   SRC_T2,  SRC_T3,  SRC_Y};
         6'd27: r = '{OP_CHK,   SRC_T0,  SRC_T0,  SRC_T0};
         6'd28: r = '{OP_MUL,   SRC_T0,  SRC_T0,  SRC_T2};
         6'd29: r = '{OP_MUL,   SRC_T2,  SRC_T0,  SRC_T2};
         6'd30: r = '{OP_SUB,   SRC_T2,  SRC_T0,  SRC_T2};
         6'd31: r = '{OP_MUL,   SRC_T2,  SRC_CLO, SRC_T2};
         6'd32: r = '{OP_MUL,   SRC_T1,  SRC_T1,  SRC_T3};
         6'd33: r = '{OP_MUL,   SRC_T3,  SRC_T1,  SRC_T3};
         6'd34: r = '{OP_SUB,   SRC_T3,  SRC_T1,  SRC_T3};
         6'd35: r = '{OP_MUL,   SRC_T3,  SRC_CHI, SRC_T3};
         6'd36: r = '{OP_ADD,   SRC_T2,  SRC_T3,  SRC_T2};
         6'd37: r = '{OP_MUL,   SRC_DX,  SRC_DX,  SRC_T3};
         6'd38: r = '{OP_MUL,   SRC_T2,  SRC_T3,  SRC_T2};
         6'd39: r = '{OP_DIV0,  SRC_T2,  SRC_SIX, SRC_T2};
         6'd40: r = '{OP_ADD,   SRC_Y,   SRC_T2,  SRC_Y};
         default: r = '{OP_END, SRC_T0,  SRC_T0,  SRC_T0};
      endcase
      return r;
   endfunction

endpackage

@@ rtl/cubic_spline_table_evaluator.sv @@
// ----------------------------------------------------------------------------
// cubic_spline_table_evaluator
// Knot table with cached-segment bisection search and a sequenced
// fixed-point cubic spline evaluation on one shared arithmetic unit.
// ----------------------------------------------------------------------------
// Load word: accepted while idle and written to the knot RAM at once.
// Evaluate word: up to 8 bisection steps, the segment reads, then the
// program on the shared unit; each divide by the width is bit-serial, each
// multiply and the divide by six run on the partial-product multiplier.
// Not ready while evaluating.
// Reset: synchronous; clears control, cache and point_count (2). Knot RAM
// has no reset and no clearing pass.
module cubic_spline_table_evaluator
   import cste_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // knot_index[7:0], x_value[39:8], y_value[71:40], curvature[103:72]
   input  logic [103:0] req_tdata,
   // cmd[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // y_result[31:0], segment[39:32]
   output logic [39:0]  rsp_tdata,
   // status[0]
   output logic [0:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_C0, ST_C0W, ST_C1, ST_C1W, ST_BRD, ST_BCMP,
      ST_K0, ST_K1, ST_K2, ST_PREP, ST_ISSUE, ST_WAIT, ST_OUT
   } state_type;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;
   localparam int   RAM_W    = 3 * KNOT_W;

   state_type         state_ff;
   logic [CNT_W-1:0]  point_count_ff;
   logic [IDX_W-1:0]  cache_ff, idx_ff, lo_ff, hi_ff;
   logic [KNOT_W-1:0] xq_ff, xlo_ff, xhi_ff, ylo_ff, yhi_ff, clo_ff, chi_ff;
   logic [KNOT_W:0]   dx_ff, na_ff, nb_ff;
   logic [WIDE_W-1:0] t0_ff, t1_ff, t2_ff, t3_ff, y_ff;
   logic [PC_W-1:0]   pc_ff;
   logic              status_ff;
   logic              rsp_valid_ff, rsp_status_ff;
   logic [31:0]       rsp_y_ff;
   logic [IDX_W-1:0]  rsp_seg_ff;

   logic              in_acc, csr_wr;
   logic [CNT_W-1:0]  n_cl;
   logic [IDX_W-1:0]  nm1, idx0, mid, rd_addr;
   logic [RAM_W-1:0]  ram_rdata;
   logic [KNOT_W-1:0] ram_x, ram_y, ram_c;
   logic [KNOT_W:0]   dx_c, na_c, nb_c;
   instr_type         instr;
   alu_req_type       alu_req;
   logic [WIDE_W-1:0] opa, opb, alu_res, y_sat_src;
   logic              alu_done;
   logic [31:0]       y_sat;

   function automatic logic [WIDE_W-1:0] sel_src(
      input src_type s,
      input logic [KNOT_W-1:0] xq, xlo, xhi, ylo, yhi, clo, chi,
      input logic [KNOT_W:0] dx, na, nb,
      input logic [WIDE_W-1:0] t0, t1, t2, t3, y
   );
      logic [WIDE_W-1:0] v;
      case (s)
         SRC_XQ:  v = {{32{xq[31]}}, xq};
         SRC_XLO: v = {{32{xlo[31]}}, xlo};
         SRC_XHI: v = {{32{xhi[31]}}, xhi};
         SRC_YLO: v = {{32{ylo[31]}}, ylo};
         SRC_YHI: v = {{32{yhi[31]}}, yhi};
         SRC_CLO: v = {{32{clo[31]}}, clo};
         SRC_CHI: v = {{32{chi[31]}}, chi};
         SRC_DX:  v = {{31{dx[32]}}, dx};
         SRC_NA:  v = {{31{na[32]}}, na};
         SRC_NB:  v = {{31{nb[32]}}, nb};
         SRC_SIX: v = 64'd6;
         SRC_T0:  v = t0;
         SRC_T1:  v = t1;
         SRC_T2:  v = t2;
         SRC_T3:  v = t3;
         SRC_Y:   v = y;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign in_acc     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {23'd0, point_count_ff};

   always_comb begin
      if (point_count_ff < CNT_W'(2)) begin
         n_cl = CNT_W'(2);
      end else if (point_count_ff > CNT_W'(MAX_POINTS)) begin
         n_cl = CNT_W'(MAX_POINTS);
      end else begin
         n_cl = point_count_ff;
      end
      nm1  = IDX_W'(n_cl - CNT_W'(1));
      idx0 = (cache_ff > nm1 - IDX_W'(1)) ? (nm1 - IDX_W'(1)) : cache_ff;
      mid  = IDX_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

      case (state_ff)
         ST_C1,
         ST_K1:   rd_addr = idx_ff + IDX_W'(1);
         ST_BRD:  rd_addr = mid;
         default: rd_addr = idx_ff;
      endcase

      ram_x = ram_rdata[KNOT_W-1:0];
      ram_y = ram_rdata[2*KNOT_W-1:KNOT_W];
      ram_c = ram_rdata[3*KNOT_W-1:2*KNOT_W];

      dx_c = {xhi_ff[31], xhi_ff} - {xlo_ff[31], xlo_ff};
      na_c = {xhi_ff[31], xhi_ff} - {xq_ff[31], xq_ff};
      nb_c = {xq_ff[31], xq_ff} - {xlo_ff[31], xlo_ff};

      instr = prog_rom(pc_ff);
      opa = sel_src(instr.a, xq_ff, xlo_ff, xhi_ff, ylo_ff, yhi_ff, clo_ff, chi_ff,
                    dx_ff, na_ff, nb_ff, t0_ff, t1_ff, t2_ff, t3_ff, y_ff);
      opb = sel_src(instr.b, xq_ff, xlo_ff, xhi_ff, ylo_ff, yhi_ff, clo_ff, chi_ff,
                    dx_ff, na_ff, nb_ff, t0_ff, t1_ff, t2_ff, t3_ff, y_ff);
      alu_req.op    = instr.op;
      alu_req.start = (state_ff == ST_ISSUE) && (instr.op != OP_END) &&
                      (instr.op != OP_CHK);

      y_sat_src = y_ff;
      if ($signed(y_sat_src) > $signed(64'h0000_0000_7FFF_FFFF)) begin
         y_sat = 32'h7FFF_FFFF;
      end else if ($signed(y_sat_src) < $signed(64'hFFFF_FFFF_8000_0000)) begin
         y_sat = 32'h8000_0000;
      end else begin
         y_sat = y_sat_src[31:0];
      end
   end

   cste_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_POINTS)
   ) u_knots (
      .clock (clock),
      .we    (in_acc && (req_tuser[0] == CMD_LOAD)),
      .waddr (req_tdata[IDX_W-1:0]),
      .wdata (req_tdata[103:8]),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   cste_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .a      (opa),
      .b      (opb),
      .done   (alu_done),
      .result (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= CNT_W'(2);
         cache_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr && !csr_paddr[2]) begin
            point_count_ff <= csr_pwdata[CNT_W-1:0];
         end
         // ST_OUT reloads the output word itself when it is taken
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (in_acc && (req_tuser[0] == CMD_EVAL)) begin
                  xq_ff    <= req_tdata[39:8];
                  idx_ff   <= idx0;
                  state_ff <= ST_C0;
               end
            end
            ST_C0:  state_ff <= ST_C0W;
            ST_C0W: begin
               if ($signed(xq_ff) < $signed(ram_x)) begin
                  lo_ff    <= '0;
                  hi_ff    <= idx_ff;
                  state_ff <= ST_BRD;
               end else begin
                  state_ff <= ST_C1;
               end
            end
            ST_C1:  state_ff <= ST_C1W;
            ST_C1W: begin
               if ($signed(xq_ff) >= $signed(ram_x)) begin
                  lo_ff    <= idx_ff;
                  hi_ff    <= nm1;
                  state_ff <= ST_BRD;
               end else begin
                  state_ff <= ST_K0;
               end
            end
            ST_BRD: begin
               if (hi_ff - lo_ff > IDX_W'(1)) begin
                  state_ff <= ST_BCMP;
               end else begin
                  idx_ff   <= lo_ff;
                  state_ff <= ST_K0;
               end
            end
            ST_BCMP: begin
               if ($signed(ram_x) > $signed(xq_ff)) begin
                  hi_ff <= mid;
               end else begin
                  lo_ff <= mid;
               end
               state_ff <= ST_BRD;
            end
            ST_K0: begin
               cache_ff <= idx_ff;
               state_ff <= ST_K1;
            end
            ST_K1: begin
               xlo_ff   <= ram_x;
               ylo_ff   <= ram_y;
               clo_ff   <= ram_c;
               state_ff <= ST_K2;
            end
            ST_K2: begin
               xhi_ff   <= ram_x;
               yhi_ff   <= ram_y;
               chi_ff   <= ram_c;
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               dx_ff <= dx_c;
               na_ff <= na_c;
               nb_ff <= nb_c;
               if (dx_c == '0) begin
                  y_ff      <= '0;
                  status_ff <= 1'b1;
                  state_ff  <= ST_OUT;
               end else begin
                  status_ff <= 1'b0;
                  state_ff  <= ST_ISSUE;
                  // extrapolate when the distance to a knot has the wrong sign
                  if ((na_c != '0) && (na_c[32] != dx_c[32])) begin
                     pc_ff <= PC_ABOVE;
                  end else if ((nb_c != '0) && (nb_c[32] != dx_c[32])) begin
                     pc_ff <= PC_BELOW;
                  end else begin
                     pc_ff <= PC_INSIDE;
                  end
               end
            end
            ST_ISSUE: begin
               case (instr.op)
                  OP_END: state_ff <= ST_OUT;
                  OP_CHK: begin
                     if ((clo_ff == '0) && (chi_ff == '0)) begin
                        state_ff <= ST_OUT;
                     end else begin
                        pc_ff <= pc_ff + PC_W'(1);
                     end
                  end
                  default: state_ff <= ST_WAIT;
               endcase
            end
            ST_WAIT: begin
               if (alu_done) begin
                  case (instr.dst)
                     SRC_T0:  t0_ff <= alu_res;
                     SRC_T1:  t1_ff <= alu_res;
                     SRC_T2:  t2_ff <= alu_res;
                     SRC_T3:  t3_ff <= alu_res;
                     default: y_ff  <= alu_res;
                  endcase
                  pc_ff    <= pc_ff + PC_W'(1);
                  state_ff <= ST_ISSUE;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_y_ff      <= status_ff ? 32'd0 : y_sat;
                  rsp_status_ff <= status_ff;
                  rsp_seg_ff    <= idx_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_seg_ff, rsp_y_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ rtl/cste_ram.sv @@
// ----------------------------------------------------------------------------
// cste_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cste_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/cste_alu.sv @@
// ----------------------------------------------------------------------------
// cste_alu
// Shared arithmetic unit: add, subtract, rounded fixed-point multiply
// (four 32x32 partial products), a bit-serial rounded divide and a rounded
// divide by six through reciprocal multiplication on the same multiplier.
// ----------------------------------------------------------------------------
module cste_alu
   import cste_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_req_type       req,
   input  logic [WIDE_W-1:0] a,
   input  logic [WIDE_W-1:0] b,
   output logic              done,
   output logic [WIDE_W-1:0] result
);

   typedef enum logic [1:0] {A_IDLE, A_MUL, A_MULFIN, A_DIV} alu_state_type;

   localparam int ACC_W = 126;
   localparam int MAG_W = 63;
   // ceil(2^65 / 6): exact floor(v / 6) for v below 2^63
   localparam logic [MAG_W-1:0] RECIP6   = 63'h5555_5555_5555_5556;
   localparam int               RECIP_SH = 65;

   alu_state_type     state_ff;
   logic              done_ff;
   logic [WIDE_W-1:0] result_ff;
   logic              neg_ff;
   logic              div6_ff;
   logic [MAG_W-1:0]  ua_ff, ub_ff;
   logic [2:0]        step_ff;
   logic [63:0]       pp_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [MAG_W-1:0]  q_ff;
   logic [WIDE_W-1:0] rem_ff;
   logic [5:0]        cnt_ff;

   logic [WIDE_W-1:0] ma, mb, uac, ubc, lim, unc, unsh, num;
   logic [31:0]       pa, pb;
   logic [63:0]       prod;
   logic [ACC_W-1:0]  pp_shift, rnd, res_w;
   logic [WIDE_W-1:0] res64, q6;
   logic [WIDE_W-1:0] rem_sh, rem_nx;
   logic              qbit;
   logic [MAG_W-1:0]  q_nx;

   always_comb begin
      ma   = a[WIDE_W-1] ? (~a + 64'd1) : a;
      mb   = b[WIDE_W-1] ? (~b + 64'd1) : b;
      uac  = (ma > SAT_LIM) ? SAT_LIM : ma;
      ubc  = (mb > SAT_LIM) ? SAT_LIM : mb;
      lim  = (req.op == OP_DIV16) ? (SAT_LIM >> FRAC_BITS) : SAT_LIM;
      unc  = (ma > lim) ? lim : ma;
      unsh = (req.op == OP_DIV16) ? (unc << FRAC_BITS) : unc;
      num  = unsh + (ubc >> 1);

      case (step_ff)
         3'd0:    begin pa = ua_ff[31:0];                 pb = ub_ff[31:0]; end
         3'd1:    begin pa = ua_ff[31:0];                 pb = {1'b0, ub_ff[62:32]}; end
         3'd2:    begin pa = {1'b0, ua_ff[62:32]};        pb = ub_ff[31:0]; end
         default: begin pa = {1'b0, ua_ff[62:32]};        pb = {1'b0, ub_ff[62:32]}; end
      endcase
      prod = pa * pb;

      // weight of the partial product taken in the previous step
      case (step_ff)
         3'd1:    pp_shift = {62'd0, pp_ff};
         3'd2,
         3'd3:    pp_shift = {30'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff[61:0], 64'd0};
      endcase

      rnd   = acc_ff + (126'd1 << (FRAC_BITS - 1));
      res_w = rnd >> FRAC_BITS;
      res64 = (res_w > {62'd0, SAT_LIM}) ? SAT_LIM : res_w[WIDE_W-1:0];
      q6    = {3'd0, acc_ff[ACC_W-1:RECIP_SH]};

      rem_sh = {rem_ff[WIDE_W-2:0], q_ff[MAG_W-1]};
      qbit   = rem_sh >= {1'b0, ub_ff};
      rem_nx = qbit ? (rem_sh - {1'b0, ub_ff}) : rem_sh;
      q_nx   = {q_ff[MAG_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            A_IDLE: begin
               if (req.start) begin
                  neg_ff <= a[WIDE_W-1] ^ b[WIDE_W-1];
                  case (req.op)
                     OP_ADD: begin
                        result_ff <= a + b;
                        done_ff   <= 1'b1;
                     end
                     OP_SUB: begin
                        result_ff <= a - b;
                        done_ff   <= 1'b1;
                     end
                     OP_MUL: begin
                        ua_ff    <= uac[MAG_W-1:0];
                        ub_ff    <= ubc[MAG_W-1:0];
                        acc_ff   <= '0;
                        step_ff  <= 3'd0;
                        div6_ff  <= 1'b0;
                        state_ff <= A_MUL;
                     end
                     // divisor is the constant six: rounded numerator times reciprocal
                     OP_DIV0: begin
                        ua_ff    <= num[MAG_W-1:0];
                        ub_ff    <= RECIP6;
                        acc_ff   <= '0;
                        step_ff  <= 3'd0;
                        div6_ff  <= 1'b1;
                        state_ff <= A_MUL;
                     end
                     OP_DIV16: begin
                        if (ubc == '0) begin
                           result_ff <= '0;
                           done_ff   <= 1'b1;
                        end else begin
                           ub_ff    <= ubc[MAG_W-1:0];
                           q_ff     <= num[MAG_W-1:0];
                           rem_ff   <= '0;
                           cnt_ff   <= '0;
                           state_ff <= A_DIV;
                        end
                     end
                     default: begin
                        result_ff <= '0;
                        done_ff   <= 1'b1;
                     end
                  endcase
               end
            end
            A_MUL: begin
               if (step_ff != 3'd4) begin
                  pp_ff <= prod;
               end
               if (step_ff != 3'd0) begin
                  acc_ff <= acc_ff + pp_shift;
               end
               if (step_ff == 3'd4) begin
                  state_ff <= A_MULFIN;
               end
               step_ff <= step_ff + 3'd1;
            end
            A_MULFIN: begin
               if (div6_ff) begin
                  result_ff <= neg_ff ? (~q6 + 64'd1) : q6;
               end else begin
                  result_ff <= neg_ff ? (~res64 + 64'd1) : res64;
               end
               done_ff   <= 1'b1;
               state_ff  <= A_IDLE;
            end
            A_DIV: begin
               rem_ff <= rem_nx;
               q_ff   <= q_nx;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(MAG_W - 1)) begin
                  result_ff <= neg_ff ? (~{1'b0, q_nx} + 64'd1) : {1'b0, q_nx};
                  done_ff   <= 1'b1;
                  state_ff  <= A_IDLE;
               end
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ rtl/cste_checker.sv @@
// ----------------------------------------------------------------------------
// cste_checker
// Port-level checks of the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cste_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [103:0] req_tdata,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // zero-width segment always reports a zero value
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[31:0] == 32'd0)
   // lower knot can never be the last slot
   `ASSERT_IMPLIES(a_seg_range, clock, reset, rsp_tvalid, rsp_tdata[39:32] != 8'hFF)

endmodule

bind cubic_spline_table_evaluator cste_checker u_cste_checker (.*);
